### design/gpio_pattern_sequencer_unit_macros.svh
`ifndef GPIO_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define GPIO_PATTERN_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define GPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define GPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gps_pkg.sv
`default_nettype none

package gps_pkg;

  localparam int ProgDepth = 4096;
  localparam int ProgAw    = $clog2(ProgDepth);
  localparam int PinCount  = 4;
  localparam logic [3:0] PinMask = 4'((1 << PinCount) - 1);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] CfgStepPeriod  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWaitTimeout = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRepeatTotal = 2'd2;

  localparam logic [9:0]  StepPeriodRst  = 10'd1;
  localparam logic [23:0] WaitTimeoutRst = 24'd100000;
  localparam logic [13:0] RepeatTotalRst = 14'd0;
  localparam logic [15:0] ByteCountMax   = 16'hFFFF;

  typedef enum logic [1:0] {
    CmdLoad,
    CmdStart,
    CmdTick,
    CmdNop
  } cmd_e;

  typedef enum logic [3:0] {
    OpSkip,
    OpIn,
    OpOut,
    OpCap8,
    OpCap16,
    OpHigh,
    OpLow,
    OpToggle,
    OpRead,
    OpBegin,
    OpRepeat,
    OpWaitLow,
    OpWaitHigh,
    OpFall,
    OpRise,
    OpStop
  } opcode_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [11:0] prog_addr;
    opcode_e     prog_opcode;
    logic [1:0]  prog_pin;
    logic [3:0]  pins_in;
    logic [31:0] timer_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  pin_drive;
    logic [3:0]  pin_dir;
    logic        byte_valid;
    logic [7:0]  data_byte;
    logic [15:0] byte_count;
    logic        running;
    logic        run_done;
    logic        run_failed;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] pin;
    opcode_e    op;
  } prog_word_t;

  typedef struct packed {
    logic              we;
    logic [ProgAw-1:0] waddr;
    prog_word_t        wdata;
    logic [ProgAw-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic      push;
    logic      two;
    out_item_t item0;
    out_item_t item1;
  } res_t;

endpackage

`default_nettype wire

### design/gpio_pattern_sequencer_unit.sv
// GPIO pattern sequencer.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one command per
// transaction: load a program word, start a run, or a timer tick with the
// sampled pins and timer value. Output channel (out_valid_o / out_stall_i /
// out_data_o) returns one result transaction per command, or two when a
// command completes two data bytes; the last flag marks the final one.
// Config port (cfg_we_i / cfg_idx_i / cfg_data_i) writes step period, wait
// timeout and repeat budget; write only while no command is outstanding.
// The first result is registered in the output queue and visible the cycle after acceptance.
// Throughput: one command per cycle unless stalled; the program word for the
// current step is prefetched from the registered program RAM as the pointer
// moves, so back-to-back ticks run without a bubble. A four-entry output queue
// decouples the sides; in_stall_o rises when fewer than two entries are free,
// so a stalled receiver stops intake once three or four results are queued.
// Reset: pins all inputs, drive latches low, no run active, registers at their
// defaults. Program memory is not cleared and must be loaded before a run.
`default_nettype none

module gpio_pattern_sequencer_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [gps_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [gps_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire gps_pkg::in_item_t               in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output gps_pkg::out_item_t                   out_data_o
);

  gps_pkg::cfg_wr_t    cfg_wr;
  gps_pkg::mem_req_t   mem_req;
  gps_pkg::prog_word_t rdata;
  gps_pkg::res_t       res;
  logic                accept;
  logic                pop;

  assign cfg_wr = '{we: cfg_we_i, idx: cfg_idx_i, data: cfg_data_i};
  assign accept = in_valid_i && !in_stall_o;
  assign pop    = out_valid_o && !out_stall_i;

  gps_prog_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  gps_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_wr),
    .accept_i  (accept),
    .in_i      (in_data_i),
    .rdata_i   (rdata),
    .mem_req_o (mem_req),
    .res_o     (res)
  );

  gps_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .data_o  (out_data_o),
    .stall_o (in_stall_o)
  );

endmodule

`default_nettype wire

### design/gps_prog_mem.sv
`default_nettype none

module gps_prog_mem (
  input  wire logic               clk_i,
  input  wire gps_pkg::mem_req_t  req_i,
  output gps_pkg::prog_word_t     rdata_o
);

  gps_pkg::prog_word_t mem_q [gps_pkg::ProgDepth];
  gps_pkg::prog_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/gps_out_fifo.sv
`default_nettype none

module gps_out_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gps_pkg::res_t      res_i,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output gps_pkg::out_item_t      data_o,
  output logic                    stall_o
);

  localparam int Depth = 4;
  localparam int Aw    = $clog2(Depth);
  localparam int Cw    = $clog2(Depth + 1);

  gps_pkg::out_item_t slot_q [Depth];
  logic [Aw-1:0] head_q, head_d, tail_q, tail_d;
  logic [Cw-1:0] count_q, count_d;
  logic [Cw-1:0] npush;

  always_comb begin
    npush   = res_i.push ? (res_i.two ? Cw'(2) : Cw'(1)) : '0;
    tail_d  = Aw'(tail_q + Aw'(npush));
    head_d  = pop_i ? Aw'(head_q + 1'b1) : head_q;
    count_d = Cw'(count_q + npush - Cw'(pop_i));
  end

  always_ff @(posedge clk_i) begin
    if (res_i.push) begin
      slot_q[tail_q] <= res_i.item0;
      if (res_i.two) begin
        slot_q[Aw'(tail_q + 1'b1)] <= res_i.item1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // room for a two-item transaction is required before accepting
  assign stall_o = count_q > Cw'(Depth - 2);
  assign valid_o = count_q != '0;
  assign data_o  = slot_q[head_q];

endmodule

`default_nettype wire

### design/gps_core.sv
`default_nettype none
`include "gpio_pattern_sequencer_unit_macros.svh"

module gps_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gps_pkg::cfg_wr_t    cfg_i,
  input  wire logic                accept_i,
  input  wire gps_pkg::in_item_t   in_i,
  input  wire gps_pkg::prog_word_t rdata_i,
  output gps_pkg::mem_req_t        mem_req_o,
  output gps_pkg::res_t            res_o
);

  localparam int Aw = gps_pkg::ProgAw;

  function automatic logic [Aw-1:0] next_addr(input logic [Aw-1:0] a);
    return (a == Aw'(gps_pkg::ProgDepth - 1)) ? '0 : Aw'(a + 1'b1);
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == gps_pkg::ByteCountMax) ? v : 16'(v + 1'b1);
  endfunction

  function automatic logic [3:0] pin_bit(input logic [1:0] pin);
    return (int'(pin) < gps_pkg::PinCount) ? (4'b0001 << pin) : 4'b0000;
  endfunction

  function automatic logic pin_level(input logic [1:0] pin, input logic [3:0] pins);
    return (int'(pin) < gps_pkg::PinCount) ? pins[pin] : 1'b0;
  endfunction

  logic [9:0]  step_period_q;
  logic [23:0] wait_timeout_q;
  logic [13:0] repeat_total_q;

  logic [Aw-1:0] ptr_q, ptr_d;
  logic [9:0]    period_q, period_d;
  logic [23:0]   wait_count_q, wait_count_d;
  logic          wait_phase_q, wait_phase_d;
  logic [13:0]   repeats_q, repeats_d;
  logic [Aw-1:0] loop_start_q, loop_start_d;
  logic          loop_valid_q, loop_valid_d;
  logic [3:0]    drive_q, drive_d;
  logic [3:0]    dir_q, dir_d;
  logic [7:0]    bit_accum_q, bit_accum_d;
  logic [2:0]    bit_fill_q, bit_fill_d;
  logic [15:0]   bytes_made_q, bytes_made_d;
  logic          run_active_q, run_active_d;
  logic          fail_q, fail_d;

  logic [9:0]  per;
  logic [23:0] limit;
  logic [10:0] period_inc;
  logic        period_hit;
  logic        lv;
  logic        wait_done;
  logic        wait_phase_nx;
  logic [23:0] wait_inc;
  logic        wait_expired;
  logic        load_ok;
  logic [1:0]  nbytes;
  logic [7:0]  byte0, byte1;
  logic [15:0] cnt0, cnt1;
  logic        ended;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_period_q  <= gps_pkg::StepPeriodRst;
      wait_timeout_q <= gps_pkg::WaitTimeoutRst;
      repeat_total_q <= gps_pkg::RepeatTotalRst;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        gps_pkg::CfgStepPeriod:  step_period_q  <= cfg_i.data[9:0];
        gps_pkg::CfgWaitTimeout: wait_timeout_q <= cfg_i.data[23:0];
        gps_pkg::CfgRepeatTotal: repeat_total_q <= cfg_i.data[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic first;
    logic target;
    logic hit;
    per        = (step_period_q == '0) ? 10'd1 : step_period_q;
    limit      = (wait_timeout_q == '0) ? 24'd1 : wait_timeout_q;
    period_inc = 11'({1'b0, period_q} + 11'd1);
    period_hit = period_inc >= {1'b0, per};
    lv         = pin_level(rdata_i.pin, in_i.pins_in);
    first      = rdata_i.op == gps_pkg::OpFall;
    target     = wait_phase_q ? !first : first;
    hit        = lv == target;
    wait_phase_nx = wait_phase_q;
    case (rdata_i.op)
      gps_pkg::OpWaitLow:  wait_done = !lv;
      gps_pkg::OpWaitHigh: wait_done = lv;
      gps_pkg::OpFall, gps_pkg::OpRise: begin
        wait_done     = hit && wait_phase_q;
        wait_phase_nx = hit ? 1'b1 : wait_phase_q;
      end
      default: wait_done = 1'b0;
    endcase
    wait_inc     = 24'(wait_count_q + 1'b1);
    wait_expired = wait_inc >= limit;
  end

  always_comb begin
    logic          exec;
    logic          run_wait;
    logic          finish;
    logic          adv;
    logic          flush;
    logic          push_en;
    logic [4:0]    push_n;
    logic [15:0]   push_val;
    logic [3:0]    pbit;
    logic [Aw-1:0] nxt;
    logic [23:0]   combined;
    logic [4:0]    total;

    ptr_d        = ptr_q;
    period_d     = period_q;
    wait_count_d = wait_count_q;
    wait_phase_d = wait_phase_q;
    repeats_d    = repeats_q;
    loop_start_d = loop_start_q;
    loop_valid_d = loop_valid_q;
    drive_d      = drive_q;
    dir_d        = dir_q;
    bit_accum_d  = bit_accum_q;
    bit_fill_d   = bit_fill_q;
    bytes_made_d = bytes_made_q;
    run_active_d = run_active_q;
    fail_d       = fail_q;

    exec     = 1'b0;
    run_wait = 1'b0;
    finish   = 1'b0;
    adv      = 1'b1;
    flush    = 1'b0;
    push_en  = 1'b0;
    push_n   = '0;
    push_val = '0;
    ended    = 1'b0;
    load_ok  = 1'b0;
    pbit     = pin_bit(rdata_i.pin);
    nxt      = next_addr(ptr_q);

    if (accept_i) begin
      case (in_i.cmd)
        gps_pkg::CmdLoad: begin
          load_ok = !run_active_q && (32'(in_i.prog_addr) < 32'(gps_pkg::ProgDepth));
        end
        gps_pkg::CmdStart: begin
          ptr_d        = '0;
          period_d     = '0;
          wait_count_d = '0;
          wait_phase_d = 1'b0;
          repeats_d    = repeat_total_q;
          loop_start_d = '0;
          loop_valid_d = 1'b0;
          bit_accum_d  = '0;
          bit_fill_d   = '0;
          bytes_made_d = '0;
          fail_d       = 1'b0;
          run_active_d = 1'b1;
        end
        gps_pkg::CmdTick: begin
          if (run_active_q) begin
            if (wait_count_q != '0) begin
              run_wait = 1'b1;
            end else if (!period_hit) begin
              period_d = period_inc[9:0];
            end else begin
              period_d = '0;
              exec     = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (exec) begin
      case (rdata_i.op)
        gps_pkg::OpIn:  dir_d = (dir_q | pbit) & gps_pkg::PinMask;
        gps_pkg::OpOut: dir_d = dir_q & ~pbit;
        gps_pkg::OpCap8: begin
          push_en  = 1'b1;
          push_n   = 5'd8;
          push_val = {8'b0, in_i.timer_value[7:0]};
        end
        gps_pkg::OpCap16: begin
          push_en  = 1'b1;
          push_n   = 5'd16;
          push_val = in_i.timer_value[15:0];
        end
        gps_pkg::OpHigh:   drive_d = (drive_q | pbit) & gps_pkg::PinMask;
        gps_pkg::OpLow:    drive_d = drive_q & ~pbit;
        gps_pkg::OpToggle: drive_d = (drive_q ^ pbit) & gps_pkg::PinMask;
        gps_pkg::OpRead: begin
          push_en  = 1'b1;
          push_n   = 5'd1;
          push_val = {15'b0, lv};
        end
        gps_pkg::OpBegin: begin
          loop_start_d = ptr_q;
          loop_valid_d = 1'b1;
        end
        gps_pkg::OpRepeat: begin
          if (repeats_q != '0) begin
            repeats_d = 14'(repeats_q - 1'b1);
            if (loop_valid_q) begin
              nxt = next_addr(loop_start_q);
            end
          end
        end
        gps_pkg::OpWaitLow, gps_pkg::OpWaitHigh, gps_pkg::OpFall, gps_pkg::OpRise: begin
          run_wait = 1'b1;
          adv      = 1'b0;
        end
        gps_pkg::OpStop: begin
          finish = 1'b1;
          adv    = 1'b0;
        end
        default: ;
      endcase
      if (adv) begin
        ptr_d = nxt;
      end
    end

    // wait_count and wait_phase are already zero when a wait first executes
    if (run_wait) begin
      if (wait_done) begin
        wait_count_d = '0;
        wait_phase_d = 1'b0;
        period_d     = '0;
        ptr_d        = next_addr(ptr_q);
      end else begin
        wait_count_d = wait_inc;
        wait_phase_d = wait_phase_nx;
        if (wait_expired) begin
          fail_d = 1'b1;
          finish = 1'b1;
        end
      end
    end

    if (finish) begin
      flush        = bit_fill_q != '0;
      bit_accum_d  = '0;
      bit_fill_d   = '0;
      wait_count_d = '0;
      wait_phase_d = 1'b0;
      run_active_d = 1'b0;
      ended        = 1'b1;
    end

    combined = ({8'b0, push_val} << bit_fill_q) | {16'b0, bit_accum_q};
    total    = 5'({2'b0, bit_fill_q} + push_n);
    nbytes   = '0;
    byte0    = '0;
    byte1    = '0;
    if (push_en) begin
      nbytes     = total[4:3];
      byte0      = combined[7:0];
      byte1      = combined[15:8];
      bit_fill_d = total[2:0];
      case (total[4:3])
        2'd0:    bit_accum_d = combined[7:0];
        2'd1:    bit_accum_d = combined[15:8];
        default: bit_accum_d = combined[23:16];
      endcase
    end else if (flush) begin
      nbytes = 2'd1;
      byte0  = bit_accum_q;
    end

    cnt0 = sat_inc(bytes_made_q);
    cnt1 = sat_inc(cnt0);
    case (nbytes)
      2'd1:    bytes_made_d = cnt0;
      2'd2:    bytes_made_d = cnt1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q        <= '0;
      period_q     <= '0;
      wait_count_q <= '0;
      wait_phase_q <= 1'b0;
      repeats_q    <= '0;
      loop_start_q <= '0;
      loop_valid_q <= 1'b0;
      drive_q      <= '0;
      dir_q        <= gps_pkg::PinMask;
      bit_accum_q  <= '0;
      bit_fill_q   <= '0;
      bytes_made_q <= '0;
      run_active_q <= 1'b0;
      fail_q       <= 1'b0;
    end else begin
      ptr_q        <= ptr_d;
      period_q     <= period_d;
      wait_count_q <= wait_count_d;
      wait_phase_q <= wait_phase_d;
      repeats_q    <= repeats_d;
      loop_start_q <= loop_start_d;
      loop_valid_q <= loop_valid_d;
      drive_q      <= drive_d;
      dir_q        <= dir_d;
      bit_accum_q  <= bit_accum_d;
      bit_fill_q   <= bit_fill_d;
      bytes_made_q <= bytes_made_d;
      run_active_q <= run_active_d;
      fail_q       <= fail_d;
    end
  end

  // read address tracks the next pointer so the word is ready on the next tick;
  // loads only land while idle and start re-reads address zero
  always_comb begin
    mem_req_o.we    = load_ok;
    mem_req_o.waddr = Aw'(in_i.prog_addr);
    mem_req_o.wdata = '{pin: in_i.prog_pin, op: in_i.prog_opcode};
    mem_req_o.raddr = ptr_d;
  end

  always_comb begin
    res_o.push             = accept_i;
    res_o.two              = nbytes == 2'd2;
    res_o.item0.pin_drive  = drive_d;
    res_o.item0.pin_dir    = dir_d;
    res_o.item0.byte_valid = nbytes != 2'd0;
    res_o.item0.data_byte  = (nbytes != 2'd0) ? byte0 : 8'd0;
    res_o.item0.byte_count = (nbytes != 2'd0) ? cnt0 : bytes_made_d;
    res_o.item0.running    = run_active_d;
    res_o.item0.run_done   = ended;
    res_o.item0.run_failed = fail_d;
    res_o.item0.last       = nbytes != 2'd2;
    res_o.item1            = res_o.item0;
    res_o.item1.data_byte  = byte1;
    res_o.item1.byte_count = cnt1;
    res_o.item1.last       = 1'b1;
  end

  `GPS_ASSERT_IMP(a_wait_needs_run, wait_count_q != '0, run_active_q, "wait pending while idle")
  `GPS_ASSERT_IMP(a_phase_in_wait, wait_count_q == '0, !wait_phase_q, "edge phase outside a wait")
  `GPS_ASSERT_IMP(a_idle_no_bits, !run_active_q, bit_fill_q == '0 && bit_accum_q == '0, "bits left after run end")
  `GPS_ASSERT_IMP(a_no_load_running, mem_req_o.we, !run_active_q, "program write during run")
  `GPS_ASSERT_NXT(a_start_clears, accept_i && in_i.cmd == gps_pkg::CmdStart, run_active_q && bytes_made_q == '0 && !fail_q, "start did not reset run")

endmodule

`default_nettype wire
